FILE: design/legik_pkg.sv
// ----------------------------------------------------------------------------
// legik_pkg
// Shared widths, constants, register indexes and arithmetic helpers for the
// leg inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package legik_pkg;

  // defaults for the top level parameters
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // angle arithmetic: degrees with 16 fraction bits
  localparam int FRAC   = 16;
  localparam int ANG_W  = 24;   // unsigned angle, 0 to 180 degrees
  localparam int ACC_W  = 28;   // signed angle sums
  localparam int CZ_W   = 26;   // signed cordic angle accumulator

  // squared magnitudes, integer square root, cordic vector
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;
  localparam int CX_W   = 36;

  // field widths
  localparam int LEN_W    = 15;
  localparam int BROLL_W  = 15;
  localparam int LEG_W    = 2;
  localparam int ROLL_W   = 17;
  localparam int HIP_W    = 17;
  localparam int KNEE_W   = 15;
  localparam int OUT_DATA_W = ((ROLL_W + HIP_W + KNEE_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ANG_W-1:0] DEG90  = ANG_W'(90 << FRAC);
  localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180 << FRAC);
  localparam logic [KNEE_W-1:0] KNEE_MAX = KNEE_W'(180 * 128);

  // register reset values
  localparam logic [LEN_W-1:0] ROLL_OFFSET_RST  = LEN_W'(600);
  localparam logic [LEN_W-1:0] UPPER_LENGTH_RST = LEN_W'(1000);
  localparam logic [LEN_W-1:0] LOWER_LENGTH_RST = LEN_W'(1000);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLL_OFFSET  = 2'd0,
    CFG_UPPER_LENGTH = 2'd1,
    CFG_LOWER_LENGTH = 2'd2
  } cfg_idx_t;

  // one digit of the restoring square root
  typedef struct packed {
    logic [SQ_W-1:0]   v;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t            o;
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    r     = {s.rem[REM_W-3:0], s.v[SQ_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    o.v   = {s.v[SQ_W-3:0], 2'b00};
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // arctangent of 2^-i in degrees, 16 fraction bits, rounded
  function automatic logic signed [CZ_W-1:0] atan_entry(input int i);
    logic signed [CZ_W-1:0] a;
    case (i)
      0:  a = CZ_W'(2949120);
      1:  a = CZ_W'(1740967);
      2:  a = CZ_W'(919879);
      3:  a = CZ_W'(466945);
      4:  a = CZ_W'(234379);
      5:  a = CZ_W'(117304);
      6:  a = CZ_W'(58666);
      7:  a = CZ_W'(29335);
      8:  a = CZ_W'(14668);
      9:  a = CZ_W'(7334);
      10: a = CZ_W'(3667);
      11: a = CZ_W'(1833);
      12: a = CZ_W'(917);
      13: a = CZ_W'(458);
      14: a = CZ_W'(229);
      15: a = CZ_W'(115);
      16: a = CZ_W'(57);
      17: a = CZ_W'(29);
      18: a = CZ_W'(14);
      19: a = CZ_W'(7);
      20: a = CZ_W'(4);
      21: a = CZ_W'(2);
      22: a = CZ_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics
// Roll, hip and knee angles of a three joint leg from one foot target.
//
//   channel   dir  fields (low bit first)
//   s_*       in   tdata: foot_x, foot_y, foot_z, body_roll; tuser: leg_index
//   m_*       out  tdata: roll_angle, hip_angle, knee_angle;
//                  tuser: reachable, clamped
//   cfg_*     in   cfg_addr: register index, cfg_data: value
//
// One word per cycle unless the output stalls. The pipeline has nine set-up
// stages, then the angle units (input register, five normalising stages,
// 32 square root stages, CORDIC_STAGES cordic stages, limit stage) and two
// output stages. The whole pipeline holds while the output word waits.
// rst (synchronous) empties the pipeline and reloads the registers.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics
  import legik_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  localparam int IN_DATA_W    = ((3 * COORD_WIDTH + BROLL_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // foot_x, foot_y, foot_z, body_roll
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // leg_index
  input  logic [LEG_W-1:0]      s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // roll_angle, hip_angle, knee_angle
  output logic [OUT_DATA_W-1:0] m_tdata,
  // reachable, clamped
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [LEN_W-1:0]      cfg_data
);

  localparam int W       = COORD_WIDTH;
  localparam int FE_LEN  = 9;
  localparam int ANG_LAT = CORDIC_STAGES + 39;

  typedef struct packed {
    logic                 valid;
    logic [LEG_W-1:0]     leg;
    logic signed [W:0]    x;
    logic signed [W:0]    y;
    logic signed [W-1:0]  z;
    logic [BROLL_W-1:0]   broll;
    logic [SQ_W-1:0]      xx;
    logic [SQ_W-1:0]      yy;
    logic [SQ_W-1:0]      zz;
    logic [2*LEN_W-1:0]   rr;
    logic [2*LEN_W-1:0]   l1sq;
    logic [2*LEN_W-1:0]   l2sq;
    logic [2*LEN_W-1:0]   l1l2;
    logic [SQ_W-1:0]      a2sq;
    logic [2*LEN_W+1:0]   l4;
    logic [2*LEN_W:0]     den;
    logic [2*LEN_W:0]     lsum;
    logic                 unreach;
    logic [SQ_W-1:0]      zp2;
    logic [SQ_W-1:0]      b2sq;
    logic signed [SQ_W-1:0] num;
    logic                 hipcl;
    logic [SQ_W-1:0]      b2n;
    logic                 khi;
    logic                 klo;
    logic [2*LEN_W:0]     nabs;
    logic [SQ_W-1:0]      n2k;
    logic [SQ_W-1:0]      den2;
    logic [SQ_W-1:0]      kn;
  } fe_t;

  typedef struct packed {
    logic               valid;
    logic [LEG_W-1:0]   leg;
    logic [BROLL_W-1:0] broll;
    logic               a1neg;
    logic               yneg;
    logic               unreach;
    logic               hipcl;
    logic               khi;
    logic               klo;
    logic               numneg;
  } side_t;

  typedef struct packed {
    logic                    valid;
    logic [LEG_W-1:0]        leg;
    logic                    unreach;
    logic                    clamped;
    logic signed [ACC_W-1:0] roll;
    logic signed [ACC_W-1:0] hip;
    logic signed [ACC_W-1:0] knee;
  } q_t;

  logic               adv;
  logic [LEN_W-1:0]   lat_offset;
  logic [LEN_W-1:0]   upper_length;
  logic [LEN_W-1:0]   lower_length;

  fe_t   fe      [1:FE_LEN];
  fe_t   fe_next [1:FE_LEN];
  side_t side    [0:ANG_LAT-1];
  q_t    q1;

  logic [ANG_W-1:0] a1_ang;
  logic [ANG_W-1:0] a2_ang;
  logic [ANG_W-1:0] b1_ang;
  logic [ANG_W-1:0] b2_ang;
  logic [ANG_W-1:0] k_ang;

  logic [ROLL_W-1:0] roll_angle;
  logic [HIP_W-1:0]  hip_angle;
  logic [KNEE_W-1:0] knee_angle;
  logic              reachable;
  logic              clamped;

  // pipeline moves whenever the output register is free or being read
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_offset   <= ROLL_OFFSET_RST;
      upper_length <= UPPER_LENGTH_RST;
      lower_length <= LOWER_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ROLL_OFFSET:  lat_offset   <= cfg_data;
        CFG_UPPER_LENGTH: upper_length <= cfg_data;
        CFG_LOWER_LENGTH: lower_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // set-up stages: mirroring, squares, reach test, knee cosine terms
  always_comb begin
    logic signed [W:0]         xe;
    logic signed [2*W+1:0]     xsq;
    logic signed [2*W+1:0]     ysq;
    logic signed [2*W-1:0]     zsq;
    logic [4*LEN_W+1:0]        nsq;
    logic [4*LEN_W+1:0]        dsq;
    xe  = {s_tdata[W-1], s_tdata[W-1:0]};
    xsq = fe[1].x * fe[1].x;
    ysq = fe[1].y * fe[1].y;
    zsq = fe[1].z * fe[1].z;
    nsq = fe[7].nabs * fe[7].nabs;
    dsq = fe[7].den * fe[7].den;

    fe_next[1]       = '0;
    fe_next[1].valid = s_tvalid;
    fe_next[1].leg   = s_tuser;
    fe_next[1].x     = s_tuser[0] ? -xe : xe;
    fe_next[1].y     = -$signed({s_tdata[2*W-1], s_tdata[2*W-1:W]});
    fe_next[1].z     = $signed(s_tdata[3*W-1:2*W]);
    fe_next[1].broll = s_tdata[3*W +: BROLL_W];

    fe_next[2]      = fe[1];
    fe_next[2].xx   = SQ_W'(xsq);
    fe_next[2].yy   = SQ_W'(ysq);
    fe_next[2].zz   = SQ_W'(zsq);
    fe_next[2].rr   = lat_offset * lat_offset;
    fe_next[2].l1sq = upper_length * upper_length;
    fe_next[2].l2sq = lower_length * lower_length;
    fe_next[2].l1l2 = upper_length * lower_length;

    fe_next[3]      = fe[2];
    fe_next[3].a2sq = fe[2].xx + fe[2].zz;
    fe_next[3].l4   = {fe[2].l1sq, 2'b00};
    fe_next[3].den  = {fe[2].l1l2, 1'b0};
    fe_next[3].lsum = (2*LEN_W+1)'(fe[2].l1sq) + (2*LEN_W+1)'(fe[2].l2sq);

    fe_next[4]         = fe[3];
    fe_next[4].unreach = fe[3].a2sq < SQ_W'(fe[3].rr);
    fe_next[4].zp2     = fe[3].a2sq - SQ_W'(fe[3].rr);

    fe_next[5]      = fe[4];
    fe_next[5].b2sq = fe[4].zp2 + fe[4].yy;

    fe_next[6]       = fe[5];
    fe_next[6].num   = $signed(SQ_W'(fe[5].lsum)) - $signed(fe[5].b2sq);
    fe_next[6].hipcl = fe[5].b2sq > SQ_W'(fe[5].l4);
    fe_next[6].b2n   = SQ_W'(fe[5].l4) - fe[5].b2sq;

    fe_next[7]      = fe[6];
    fe_next[7].khi  = fe[6].num > $signed(SQ_W'(fe[6].den));
    fe_next[7].klo  = fe[6].num < -$signed(SQ_W'(fe[6].den));
    fe_next[7].nabs = fe[6].num[SQ_W-1] ? (2*LEN_W+1)'(-fe[6].num)
                                        : (2*LEN_W+1)'(fe[6].num);

    fe_next[8]      = fe[7];
    fe_next[8].n2k  = SQ_W'(nsq);
    fe_next[8].den2 = SQ_W'(dsq);

    fe_next[9]    = fe[8];
    fe_next[9].kn = fe[8].den2 - fe[8].n2k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= FE_LEN; i++) fe[i].valid <= 1'b0;
    end else if (adv) begin
      fe <= fe_next;
    end
  end

  // five angle units
  legik_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_a1 (
    .clk(clk), .en(adv), .n2(fe[9].xx), .d2(fe[9].zz), .angle(a1_ang)
  );
  legik_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_a2 (
    .clk(clk), .en(adv), .n2(fe[9].zp2), .d2(SQ_W'(fe[9].rr)), .angle(a2_ang)
  );
  legik_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_b1 (
    .clk(clk), .en(adv), .n2(fe[9].yy), .d2(fe[9].zp2), .angle(b1_ang)
  );
  legik_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_b2 (
    .clk(clk), .en(adv), .n2(fe[9].b2n), .d2(fe[9].b2sq), .angle(b2_ang)
  );
  legik_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_k (
    .clk(clk), .en(adv), .n2(fe[9].kn), .d2(fe[9].n2k), .angle(k_ang)
  );

  // side information alongside the angle units
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANG_LAT; i++) side[i].valid <= 1'b0;
    end else if (adv) begin
      side[0].valid   <= fe[9].valid;
      side[0].leg     <= fe[9].leg;
      side[0].broll   <= fe[9].broll;
      side[0].a1neg   <= ((fe[9].x < 0) != (fe[9].z < 0)) && (fe[9].x != '0);
      side[0].yneg    <= fe[9].y < 0;
      side[0].unreach <= fe[9].unreach;
      side[0].hipcl   <= fe[9].hipcl;
      side[0].khi     <= fe[9].khi;
      side[0].klo     <= fe[9].klo;
      side[0].numneg  <= fe[9].num[SQ_W-1];
      for (int i = 1; i < ANG_LAT; i++) side[i] <= side[i-1];
    end
  end

  // angle sums
  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] a1;
    logic signed [ACC_W-1:0] b1;
    logic signed [ACC_W-1:0] br;
    if (rst) begin
      q1.valid <= 1'b0;
    end else if (adv) begin
      a1 = $signed(ACC_W'(a1_ang));
      b1 = $signed(ACC_W'(b1_ang));
      br = $signed({{(ACC_W-BROLL_W-9){side[ANG_LAT-1].broll[BROLL_W-1]}},
                    side[ANG_LAT-1].broll, 9'd0});
      if (side[ANG_LAT-1].a1neg) a1 = -a1;
      if (side[ANG_LAT-1].yneg)  b1 = -b1;
      q1.valid   <= side[ANG_LAT-1].valid;
      q1.leg     <= side[ANG_LAT-1].leg;
      q1.unreach <= side[ANG_LAT-1].unreach;
      q1.clamped <= side[ANG_LAT-1].hipcl || side[ANG_LAT-1].khi
                    || side[ANG_LAT-1].klo;
      if (side[ANG_LAT-1].leg[0]) q1.roll <= a1 + $signed(ACC_W'(a2_ang)) + br;
      else                        q1.roll <= a1 + $signed(ACC_W'(a2_ang)) - br;
      if (side[ANG_LAT-1].hipcl) q1.hip <= b1;
      else                       q1.hip <= b1 + $signed(ACC_W'(b2_ang));
      if (side[ANG_LAT-1].khi)       q1.knee <= '0;
      else if (side[ANG_LAT-1].klo)  q1.knee <= $signed(ACC_W'(DEG180));
      else if (side[ANG_LAT-1].numneg)
        q1.knee <= $signed(ACC_W'(DEG180)) - $signed(ACC_W'(k_ang));
      else
        q1.knee <= $signed(ACC_W'(k_ang));
    end
  end

  // reflection for the rear legs, rounding to 1/128 degree, output word
  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] h;
    logic signed [ACC_W-1:0] k;
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      r = q1.leg[1] ? $signed(ACC_W'(DEG180)) - q1.roll : q1.roll;
      r = r + ACC_W'(256);
      h = q1.hip + ACC_W'(256);
      k = q1.knee + ACC_W'(256);
      m_tvalid <= q1.valid;
      if (q1.unreach) begin
        roll_angle <= '0;
        hip_angle  <= '0;
        knee_angle <= '0;
        reachable  <= 1'b0;
        clamped    <= 1'b0;
      end else begin
        roll_angle <= r[9 +: ROLL_W];
        hip_angle  <= h[9 +: HIP_W];
        knee_angle <= k[9 +: KNEE_W];
        reachable  <= 1'b1;
        clamped    <= q1.clamped;
      end
    end
  end

  assign m_tdata = OUT_DATA_W'({knee_angle, hip_angle, roll_angle});
  assign m_tuser = {clamped, reachable};

endmodule

FILE: design/legik_angle.sv
// ----------------------------------------------------------------------------
// legik_angle
// Pipelined atan(sqrt(n2)/sqrt(d2)) in 0..90 degrees: even normalising shift,
// two bit-serial square roots and a vectoring cordic, one stage per step.
// ----------------------------------------------------------------------------
module legik_angle
  import legik_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_W-1:0]  n2,
  input  logic [SQ_W-1:0]  d2,
  output logic [ANG_W-1:0] angle
);

  localparam int NORM_STEPS = 5;
  localparam int FLAG_LEN   = 1 + NORM_STEPS + ROOT_W + CORDIC_STAGES;

  typedef struct packed {
    logic nz;
    logic dz;
  } zflag_t;

  logic [SQ_W-1:0] nn [0:NORM_STEPS];
  logic [SQ_W-1:0] dd [0:NORM_STEPS];
  logic [SQ_W-1:0] mm [0:NORM_STEPS];
  zflag_t          fl [0:FLAG_LEN-1];

  sqrt_t sn [0:ROOT_W];
  sqrt_t sd [0:ROOT_W];

  logic signed [CX_W-1:0] cx [0:CORDIC_STAGES];
  logic signed [CX_W-1:0] cy [0:CORDIC_STAGES];
  logic signed [CZ_W-1:0] cz [0:CORDIC_STAGES];

  // input register, zero flags and larger magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      nn[0]    <= n2;
      dd[0]    <= d2;
      mm[0]    <= (n2 > d2) ? n2 : d2;
      fl[0].nz <= (n2 == '0);
      fl[0].dz <= (d2 == '0);
    end
  end

  // zero flags follow the data
  genvar g;
  generate
    for (g = 1; g < FLAG_LEN; g++) begin : g_flag
      always_ff @(posedge clk) begin
        if (en) fl[g] <= fl[g-1];
      end
    end

    // normalise by 4^k until the larger value reaches 2^60
    for (g = 1; g <= NORM_STEPS; g++) begin : g_norm
      localparam int SH = SQ_W >> g;
      always_ff @(posedge clk) begin
        if (en) begin
          if (mm[g-1] < (SQ_W'(1) << (62 - SH))) begin
            nn[g] <= nn[g-1] << SH;
            dd[g] <= dd[g-1] << SH;
            mm[g] <= mm[g-1] << SH;
          end else begin
            nn[g] <= nn[g-1];
            dd[g] <= dd[g-1];
            mm[g] <= mm[g-1];
          end
        end
      end
    end
  endgenerate

  // square roots, one result bit per stage
  always_comb begin
    sn[0].v    = nn[NORM_STEPS];
    sn[0].rem  = '0;
    sn[0].root = '0;
    sd[0].v    = dd[NORM_STEPS];
    sd[0].rem  = '0;
    sd[0].root = '0;
  end

  generate
    for (g = 1; g <= ROOT_W; g++) begin : g_sqrt
      always_ff @(posedge clk) begin
        if (en) begin
          sn[g] <= sqrt_step(sn[g-1]);
          sd[g] <= sqrt_step(sd[g-1]);
        end
      end
    end
  endgenerate

  // cordic start vector: x from the denominator root, y from the numerator
  always_comb begin
    cx[0] = $signed(CX_W'(sd[ROOT_W].root));
    cy[0] = $signed(CX_W'(sn[ROOT_W].root));
    cz[0] = '0;
  end

  generate
    for (g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      always_ff @(posedge clk) begin
        if (en) begin
          if (cy[g] > 0) begin
            cx[g+1] <= cx[g] + (cy[g] >>> g);
            cy[g+1] <= cy[g] - (cx[g] >>> g);
            cz[g+1] <= cz[g] + atan_entry(g);
          end else begin
            cx[g+1] <= cx[g] - (cy[g] >>> g);
            cy[g+1] <= cy[g] + (cx[g] >>> g);
            cz[g+1] <= cz[g] - atan_entry(g);
          end
        end
      end
    end
  endgenerate

  // limit to 0..90 and apply the zero cases
  always_ff @(posedge clk) begin
    if (en) begin
      if (fl[FLAG_LEN-1].nz) begin
        angle <= '0;
      end else if (fl[FLAG_LEN-1].dz) begin
        angle <= DEG90;
      end else if (cz[CORDIC_STAGES] < 0) begin
        angle <= '0;
      end else if (cz[CORDIC_STAGES] > $signed(CZ_W'(DEG90))) begin
        angle <= DEG90;
      end else begin
        angle <= ANG_W'(cz[CORDIC_STAGES]);
      end
    end
  end

endmodule

FILE: design/legik_checker.sv
// ----------------------------------------------------------------------------
// legik_checker
// Port level checks on the leg inverse kinematics block, bound to the top.
// ----------------------------------------------------------------------------
module legik_checker
  import legik_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready
);

  // a held output word does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // input side stalls exactly when the output word is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // an unreachable target gives zero angles and no clamp flag
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("unreachable word carries data");

  // knee never beyond 180 degrees
  a_knee: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ROLL_W+HIP_W +: KNEE_W] <= KNEE_MAX)
    else $error("knee angle out of range");

  // pipeline empty after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind leg_inverse_kinematics legik_checker u_legik_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid),
  .m_tready(m_tready)
);

FILE: verif/tb_leg_inverse_kinematics.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_leg_inverse_kinematics
// Self-checking bench for the leg inverse kinematics pipeline. Foot targets
// are streamed in with random gaps and output stalls; an in-bench angle
// predictor works out each joint word, and every output word is compared
// field by field with the oldest queued prediction. Register settings are
// changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_leg_inverse_kinematics;
  import legik_pkg::*;

  localparam int CW       = 16;
  localparam int STAGES   = 16;
  localparam int IN_W     = ((3 * CW + BROLL_W + 7) / 8) * 8;
  localparam int LATENCY  = STAGES + 50;
  localparam int CYC_LIMIT = 600000;

  typedef struct packed {
    logic signed [ROLL_W-1:0] roll;
    logic signed [HIP_W-1:0]  hip;
    logic [KNEE_W-1:0]        knee;
    logic                     reach;
    logic                     clamp;
  } joint_word_t;

  logic                  clk;
  logic                  rst;
  logic [IN_W-1:0]       s_tdata;
  logic [LEG_W-1:0]      s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [LEN_W-1:0]      cfg_data;

  joint_word_t joint_q[$];
  longint      offset_len, upper_len, lower_len;
  int          fail_count;
  longint      cycle_count = 0;
  int          stall_left = 0;
  bit          quiet;   // no idling in the final part of the run

  leg_inverse_kinematics #(.COORD_WIDTH(CW), .CORDIC_STAGES(STAGES)) u_dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYC_LIMIT) begin
      $display("leg_inverse_kinematics regression: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // predictor arithmetic
  // ------------------------------------------------------------------------
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint floor_root(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v   -= res + bit_v;
        res  = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint atan_deg(int i);
    longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  // atan of sqrt(n2)/sqrt(d2), degrees with 16 fraction bits
  function automatic longint angle_of_squares(longint unsigned n2,
                                              longint unsigned d2);
    longint unsigned mx;
    longint xv, yv, zacc, dx, dy;
    zacc = 0;
    if (n2 == 0) return 0;
    if (d2 == 0) return longint'(90) << FRAC;
    mx = (n2 > d2) ? n2 : d2;
    for (int i = 0; i < 32 && mx < (64'd1 << 60); i++) begin
      n2 <<= 2; d2 <<= 2; mx <<= 2;
    end
    xv = floor_root(d2);
    yv = floor_root(n2);
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = sra(yv, i);
      dy = sra(xv, i);
      if (yv > 0) begin
        xv += dx; yv -= dy; zacc += atan_deg(i);
      end else begin
        xv -= dx; yv += dy; zacc -= atan_deg(i);
      end
    end
    if (zacc < 0) zacc = 0;
    if (zacc > (longint'(90) << FRAC)) zacc = longint'(90) << FRAC;
    return zacc;
  endfunction

  // round to 1/128 degree, half towards +infinity
  function automatic longint to_out_units(longint v);
    longint t;
    t = v + (longint'(1) << (FRAC - 8));
    if (t >= 0) return t >>> (FRAC - 7);
    return -((-t + ((longint'(1) << (FRAC - 7)) - 1)) >>> (FRAC - 7));
  endfunction

  function automatic joint_word_t predict_joints(logic [1:0] leg, logic signed [15:0] fx,
      logic signed [15:0] fy, logic signed [15:0] fz, logic signed [14:0] broll_in);
    joint_word_t w;
    longint x, y, z, broll, a1, a2, b1, b2, k, roll, num;
    longint unsigned a2sq, r2, zp2, b2sq, l4, den, n2;
    bit clamp;
    x = fx; y = -longint'(fy); z = fz;
    broll = longint'(broll_in) * 512;
    clamp = 0;
    w = '0;
    if (leg == 1 || leg == 3) x = -x;
    a2sq = x * x + z * z;
    r2 = offset_len * offset_len;
    if (a2sq < r2) return w;
    zp2 = a2sq - r2;
    a1 = angle_of_squares(x * x, z * z);
    if (((x < 0) != (z < 0)) && x != 0) a1 = -a1;
    a2 = angle_of_squares(zp2, r2);
    b2sq = zp2 + y * y;
    b1 = angle_of_squares(y * y, zp2);
    if (y < 0) b1 = -b1;
    l4 = 4 * upper_len * upper_len;
    if (b2sq > l4) begin
      b2 = 0; clamp = 1;
    end else begin
      b2 = angle_of_squares(l4 - b2sq, b2sq);
    end
    num = upper_len * upper_len + lower_len * lower_len - longint'(b2sq);
    den = 2 * upper_len * lower_len;
    if (num > longint'(den)) begin
      k = 0; clamp = 1;
    end else if (num < -longint'(den)) begin
      k = longint'(180) << FRAC; clamp = 1;
    end else begin
      n2 = num * num;
      k = angle_of_squares(den * den - n2, n2);
      if (num < 0) k = (longint'(180) << FRAC) - k;
    end
    roll = a1 + a2;
    if (leg == 0 || leg == 2) roll -= broll;
    else roll += broll;
    if (leg == 2 || leg == 3) roll = (longint'(180) << FRAC) - roll;
    w.roll  = ROLL_W'(to_out_units(roll));
    w.hip   = HIP_W'(to_out_units(b1 + b2));
    w.knee  = KNEE_W'(to_out_units(k));
    w.reach = 1'b1;
    w.clamp = clamp;
    return w;
  endfunction

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------
  task automatic idle_burst();
    int n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 18);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_target(logic [1:0] leg, logic signed [15:0] fx,
      logic signed [15:0] fy, logic signed [15:0] fz, logic signed [14:0] broll);
    idle_burst();
    s_tdata  <= IN_W'({broll, fz, fy, fx});
    s_tuser  <= leg;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    joint_q.push_back(predict_joints(leg, fx, fy, fz, broll));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (joint_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [LEN_W-1:0] value);
    cfg_addr  <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROLL_OFFSET:  offset_len = value;
      CFG_UPPER_LENGTH: upper_len  = value;
      CFG_LOWER_LENGTH: lower_len  = value;
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [LEN_W-1:0] r, logic [LEN_W-1:0] l1,
                              logic [LEN_W-1:0] l2);
    drain();
    write_reg(CFG_ROLL_OFFSET, r);
    write_reg(CFG_UPPER_LENGTH, l1);
    write_reg(CFG_LOWER_LENGTH, l2);
    cfg_valid <= 1'b0;
  endtask

  // output stalls in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) m_tready <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= int'($urandom_range(1, 18));
    end
  end

  // result checker
  always @(posedge clk) begin
    joint_word_t exp_w, got;
    if (!rst && m_tvalid && m_tready) begin
      got.roll  = m_tdata[ROLL_W-1:0];
      got.hip   = m_tdata[ROLL_W +: HIP_W];
      got.knee  = m_tdata[ROLL_W+HIP_W +: KNEE_W];
      got.reach = m_tuser[0];
      got.clamp = m_tuser[1];
      if (joint_q.size() == 0) begin
        $display("%0t unexpected word: actual %p", $time, got);
        fail_count++;
      end else begin
        exp_w = joint_q.pop_front();
        if (got.roll !== exp_w.roll) begin
          $display("%0t roll: expected %0d actual %0d", $time, exp_w.roll, got.roll);
          fail_count++;
        end
        if (got.hip !== exp_w.hip) begin
          $display("%0t hip: expected %0d actual %0d", $time, exp_w.hip, got.hip);
          fail_count++;
        end
        if (got.knee !== exp_w.knee) begin
          $display("%0t knee: expected %0d actual %0d", $time, exp_w.knee, got.knee);
          fail_count++;
        end
        if (got.reach !== exp_w.reach) begin
          $display("%0t reachable: expected %0b actual %0b", $time, exp_w.reach,
                   got.reach);
          fail_count++;
        end
        if (got.clamp !== exp_w.clamp) begin
          $display("%0t clamped: expected %0b actual %0b", $time, exp_w.clamp,
                   got.clamp);
          fail_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  function automatic logic signed [14:0] rand_roll();
    return 15'($signed($urandom_range(0, 23040)) - 11520);
  endfunction

  // extremes of fields, zero denominators and unreachable targets
  task automatic test_directed();
    send_target(0, 0, 0, 0, 0);              // unreachable
    send_target(0, 0, 0, 1500, 0);           // straight down
    send_target(1, 300, -200, 1400, 100);
    send_target(2, -300, 200, 1400, -100);
    send_target(3, 400, 100, -1200, 11520);
    send_target(0, 2000, 0, 0, -11520);      // zero denominator in x/z
    send_target(1, -2000, 0, 0, 0);
    send_target(2, 600, 0, 0, 0);            // foot on the roll offset
    send_target(0, 32767, 32767, 32767, 0);  // over-reach, clamped
    send_target(3, -32768, -32768, -32768, 0);
    send_target(1, 0, 0, 600, 0);            // knee fully folded
    send_target(0, 100, 50, 650, 15'sh3fff); // body roll out of range
    send_target(2, 100, 50, 650, 15'sh4000);
    send_target(3, 700, -1500, 900, 0);
  endtask

  // zero roll offset, then full-scale lengths: zero over zero in the angle terms
  task automatic test_zero_geometry();
    set_geometry(0, 1, 1);
    send_target(0, 0, 0, 0, 0);
    send_target(1, 1, 0, 1, 0);
    send_target(2, 0, 1, 0, 0);
    set_geometry(32767, 32767, 32767);
    send_target(0, 32767, 0, 32767, 0);
    send_target(3, -32768, 1000, -32768, 500);
    send_target(1, 100, 100, 100, 0);
  endtask

  // random targets around a working geometry, plus noise
  task automatic test_random(int count, int reach_scale);
    logic signed [15:0] fx, fy, fz;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        fx = 16'($urandom); fy = 16'($urandom); fz = 16'($urandom);
      end else begin
        fx = 16'($signed($urandom_range(0, 2 * reach_scale)) - reach_scale);
        fy = 16'($signed($urandom_range(0, 2 * reach_scale)) - reach_scale);
        fz = 16'($signed($urandom_range(0, 2 * reach_scale)) - reach_scale);
      end
      send_target(2'($urandom_range(0, 3)), fx, fy, fz, rand_roll());
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tdata = '0; s_tuser = '0; s_tvalid = 1'b0;
    cfg_valid = 1'b0; cfg_addr = CFG_ROLL_OFFSET; cfg_data = '0;
    m_tready = 1'b1;
    fail_count = 0; quiet = 0;
    offset_len = ROLL_OFFSET_RST;
    upper_len  = UPPER_LENGTH_RST;
    lower_len  = LOWER_LENGTH_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_zero_geometry();
    set_geometry(600, 1000, 1000);
    test_random(300, 2500);
    set_geometry(250, 1800, 1200);
    test_random(200, 3500);
    set_geometry(5, 40, 60);
    test_random(150, 120);
    set_geometry(600, 1000, 1000);
    quiet = 1;
    test_random(250, 2500);
    drain();

    if (fail_count == 0) begin
      $display("leg_inverse_kinematics regression: pass");
    end else begin
      $display("leg_inverse_kinematics regression: fail");
    end
    $finish;
  end

endmodule
